### rtl/rcpd_pkg.sv
package rcpd_pkg;

  // default geometry and count width
  localparam int GRID_MAX_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;

  // bitmap word
  localparam int MAP_WIDTH     = 64;
  localparam int MAP_DEPTH_DEF = GRID_MAX_DEF * (GRID_MAX_DEF / MAP_WIDTH);

  // configuration registers
  localparam int      REG_COUNT  = 2;
  localparam logic    REG_WIDTH  = 1'b0;
  localparam logic    REG_HEIGHT = 1'b1;
  localparam logic [8:0] SIZE_RESET = 9'd256;

  // pattern text characters
  localparam logic [7:0] CH_END  = 8'h21;  // '!'
  localparam logic [7:0] CH_DEAD = 8'h62;  // 'b'
  localparam logic [7:0] CH_LIVE = 8'h6F;  // 'o'
  localparam logic [7:0] CH_NEXT = 8'h24;  // '$'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam int         DEC_BASE = 10;

  typedef enum logic [1:0] {
    FUNC_FEED  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

endpackage

### rtl/rcpd_map_ram.sv
module rcpd_map_ram #(
  parameter int DEPTH = rcpd_pkg::MAP_DEPTH_DEF,
  parameter int WIDTH = rcpd_pkg::MAP_WIDTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rle_cell_pattern_decoder.sv
// Run-length pattern decoder with a stored cell bitmap.
// Input channel (in_valid_i / in_stall_o) takes one request per item: feed a
// text character, read one 64-cell word of a row, or clear and restart.
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// the word read (zero unless a read), column, row, end and clip flags.
// A request is taken only while the decoder is idle; the result sits in an
// output register, and a new request is taken as that result is collected.
// For characters other than 'b'/'o', reads and clears, the accepting edge moves
// to the DONE state, which registers the result; a run first passes a read and
// a write-back state for each 64-cell bitmap word it touches (read then write
// back through the single RAM port) before DONE. The result can be collected at
// the following edge at the earliest. A new request is not taken before the previous one has returned to idle.
// Reset and a clear request sweep the bitmap RAM one word a cycle,
// all GRID_MAX*GRID_MAX/64 words (1024 at the default size); no request is taken
// meanwhile, but the APB registers stay writable. A clear returns its result
// before the sweep starts. Grid size registers sit at 0x0 (width) and 0x4
// (height) and are kept across a clear.
// If the receiver stalls, the result is held and the next request waits.
module rle_cell_pattern_decoder #(
  parameter int GRID_MAX   = rcpd_pkg::GRID_MAX_DEF,
  parameter int COUNT_BITS = rcpd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  read_row_i,
  input  logic [1:0]  read_word_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] row_bits_o,
  output logic [8:0]  cur_col_o,
  output logic [8:0]  cur_row_o,
  output logic        finished_o,
  output logic        clipped_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WORD_W    = rcpd_pkg::MAP_WIDTH;
  localparam int WPR       = GRID_MAX / WORD_W;
  localparam int MAP_DEPTH = GRID_MAX * WPR;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int WIDX_W    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int POS_W     = $clog2(GRID_MAX + 1);
  localparam int SW        = (POS_W > 9) ? POS_W : 9;
  localparam int STW       = ((COUNT_BITS > SW) ? COUNT_BITS : SW) + 1;
  localparam int CW4       = COUNT_BITS + 4;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_WR    = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [POS_W-1:0]      col_q, col_d;
  logic [POS_W-1:0]      row_q, row_d;
  logic [COUNT_BITS-1:0] pend_q, pend_d;
  logic                  end_q, end_d;
  logic                  clip_q, clip_d;
  logic                  clr_pend_q, clr_pend_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic                  out_valid_q, out_valid_d;
  logic [8:0]            width_q, height_q;

  // run and result bookkeeping, no reset needed
  logic [5:0]            run_s_lo_q, run_s_lo_d;
  logic [5:0]            run_e_lo_q, run_e_lo_d;
  logic [WIDX_W-1:0]     wfirst_q, wfirst_d;
  logic [WIDX_W-1:0]     wlast_q, wlast_d;
  logic [WIDX_W-1:0]     wcur_q, wcur_d;
  logic                  alive_q, alive_d;
  logic                  bits_hit_q, bits_hit_d;
  logic [63:0]           row_bits_q, row_bits_d;
  logic [8:0]            cur_col_q, cur_col_d;
  logic [8:0]            cur_row_q, cur_row_d;
  logic                  fin_q, fin_d;
  logic                  clipo_q, clipo_d;

  logic                  in_acc;
  logic                  cfg_wr;

  // RAM port
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  // request decode arithmetic
  logic [COUNT_BITS-1:0] run_n;
  logic [STW-1:0]        s_x, stop_x, w_eff, h_eff, e_x, e_m1, row_x, row_adv;
  logic                  run_clip, run_write;
  logic [POS_W-1:0]      col_run, row_next;
  logic [7:0]            dig8;
  logic [CW4-1:0]        dig_v;
  logic [COUNT_BITS-1:0] pend_dig;
  logic                  is_digit;
  logic                  rd_hit;
  logic [AW-1:0]         rd_addr, run_addr;
  logic [5:0]            m_lo, m_hi;
  logic [63:0]           run_mask, word_new;
  logic [POS_W+8:0]      col_ext, row_ext;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rcpd_pkg::REG_HEIGHT) ? {23'd0, height_q} : {23'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rcpd_pkg::SIZE_RESET;
      height_q <= rcpd_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == rcpd_pkg::REG_WIDTH) begin
        width_q <= pwdata[8:0];
      end else begin
        height_q <= pwdata[8:0];
      end
    end
  end

  // ---------------- run / digit arithmetic ----------------
  always_comb begin
    run_n     = (pend_q == '0) ? COUNT_BITS'(1) : pend_q;
    s_x       = STW'(col_q);
    row_x     = STW'(row_q);
    stop_x    = s_x + STW'(run_n);
    w_eff     = (STW'(width_q) < STW'(GRID_MAX)) ? STW'(width_q) : STW'(GRID_MAX);
    h_eff     = (STW'(height_q) < STW'(GRID_MAX)) ? STW'(height_q) : STW'(GRID_MAX);
    e_x       = (stop_x < w_eff) ? stop_x : w_eff;
    e_m1      = e_x - STW'(1);
    run_clip  = (stop_x > w_eff) || (row_x >= h_eff);
    run_write = (row_x < h_eff) && (s_x < e_x);
    col_run   = (stop_x < STW'(GRID_MAX)) ? POS_W'(stop_x) : POS_W'(GRID_MAX);
    row_adv   = row_x + STW'(run_n);
    row_next  = (row_adv < STW'(GRID_MAX)) ? POS_W'(row_adv) : POS_W'(GRID_MAX);

    is_digit  = (char_code_i >= rcpd_pkg::CH_ZERO) && (char_code_i <= rcpd_pkg::CH_NINE);
    dig8      = char_code_i - rcpd_pkg::CH_ZERO;
    dig_v     = CW4'(pend_q) * CW4'(rcpd_pkg::DEC_BASE) + CW4'(dig8[3:0]);
    pend_dig  = (|dig_v[CW4-1:COUNT_BITS]) ? '1 : dig_v[COUNT_BITS-1:0];

    rd_hit    = (32'(read_row_i) < 32'(GRID_MAX)) && (32'(read_word_i) < 32'(WPR));
    rd_addr   = AW'(32'(read_row_i) * 32'(WPR) + 32'(read_word_i));
    run_addr  = AW'(32'(row_q) * 32'(WPR) + 32'(wcur_q));

    // bit range of the run within the current word
    m_lo      = (wcur_q == wfirst_q) ? run_s_lo_q : 6'd0;
    m_hi      = (wcur_q == wlast_q) ? run_e_lo_q : 6'd63;
    run_mask  = ({64{1'b1}} << m_lo) & ({64{1'b1}} >> (6'd63 - m_hi));
    word_new  = alive_q ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);

    col_ext   = {9'd0, col_q};
    row_ext   = {9'd0, row_q};
  end

  // ---------------- RAM port mux ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = run_addr;
    ram_wdata = word_new;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (in_acc && func_i == rcpd_pkg::FUNC_READ && rd_hit) begin
          ram_re   = 1'b1;
          ram_addr = rd_addr;
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_WR: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  rcpd_map_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (WORD_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    pend_d      = pend_q;
    end_d       = end_q;
    clip_d      = clip_q;
    clr_pend_d  = clr_pend_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    run_s_lo_d  = run_s_lo_q;
    run_e_lo_d  = run_e_lo_q;
    wfirst_d    = wfirst_q;
    wlast_d     = wlast_q;
    wcur_d      = wcur_q;
    alive_d     = alive_q;
    bits_hit_d  = bits_hit_q;
    row_bits_d  = row_bits_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    fin_d       = fin_q;
    clipo_d     = clipo_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAP_DEPTH - 1)) begin
          clr_addr_d = '0;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d    = ST_DONE;
          bits_hit_d = 1'b0;
          unique case (func_i)
            rcpd_pkg::FUNC_FEED: begin
              if (!end_q) begin
                if (char_code_i == rcpd_pkg::CH_END) begin
                  end_d = 1'b1;
                end else if (is_digit) begin
                  pend_d = pend_dig;
                end else if (char_code_i == rcpd_pkg::CH_DEAD ||
                             char_code_i == rcpd_pkg::CH_LIVE) begin
                  clip_d     = clip_q | run_clip;
                  col_d      = col_run;
                  pend_d     = '0;
                  alive_d    = (char_code_i == rcpd_pkg::CH_LIVE);
                  run_s_lo_d = col_q[5:0];
                  run_e_lo_d = e_m1[5:0];
                  wfirst_d   = WIDX_W'(s_x >> 6);
                  wlast_d    = WIDX_W'(e_m1 >> 6);
                  wcur_d     = WIDX_W'(s_x >> 6);
                  if (run_write) begin
                    state_d = ST_RD;
                  end
                end else if (char_code_i == rcpd_pkg::CH_NEXT) begin
                  col_d  = '0;
                  row_d  = row_next;
                  pend_d = '0;
                end
              end
            end
            rcpd_pkg::FUNC_READ: begin
              bits_hit_d = rd_hit;
            end
            rcpd_pkg::FUNC_CLEAR: begin
              col_d      = '0;
              row_d      = '0;
              pend_d     = '0;
              end_d      = 1'b0;
              clip_d     = 1'b0;
              clr_pend_d = 1'b1;
              clr_addr_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (wcur_q == wlast_q) begin
          state_d = ST_DONE;
        end else begin
          wcur_d  = wcur_q + WIDX_W'(1);
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        // output slot is free here: the request was only taken when it drained
        out_valid_d = 1'b1;
        row_bits_d  = bits_hit_q ? ram_rdata : '0;
        cur_col_d   = col_ext[8:0];
        cur_row_d   = row_ext[8:0];
        fin_d       = end_q;
        clipo_d     = clip_q;
        if (clr_pend_q) begin
          clr_pend_d = 1'b0;
          state_d    = ST_CLEAR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      end_q       <= 1'b0;
      clip_q      <= 1'b0;
      clr_pend_q  <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      clip_q      <= clip_d;
      clr_pend_q  <= clr_pend_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_s_lo_q <= run_s_lo_d;
    run_e_lo_q <= run_e_lo_d;
    wfirst_q   <= wfirst_d;
    wlast_q    <= wlast_d;
    wcur_q     <= wcur_d;
    alive_q    <= alive_d;
    bits_hit_q <= bits_hit_d;
    row_bits_q <= row_bits_d;
    cur_col_q  <= cur_col_d;
    cur_row_q  <= cur_row_d;
    fin_q      <= fin_d;
    clipo_q    <= clipo_d;
  end

  assign out_valid_o = out_valid_q;
  assign row_bits_o  = row_bits_q;
  assign cur_col_o   = cur_col_q;
  assign cur_row_o   = cur_row_q;
  assign finished_o  = fin_q;
  assign clipped_o   = clipo_q;

`ifndef ASSERT_OFF
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !out_valid_q)
    else $error("result produced while output register still full");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without completing a request");

  a_word_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_WR) |-> (wcur_q <= wlast_q))
    else $error("run word counter passed the last word");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= POS_W'(GRID_MAX)) && (row_q <= POS_W'(GRID_MAX)))
    else $error("position beyond grid limit");
`endif

endmodule
